// File: hw/rtl/char_lcd_nibble_writer_assert.svh
// assertion macros for the character lcd nibble writer
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CLNW_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clnw assertion failed: same-cycle implication");

// next-cycle implication, sampled on clk, quiet during reset
`define CLNW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clnw assertion failed: next-cycle implication");

`endif

// File: hw/rtl/clnw_pkg.sv
// shared types, codes and constants of the character lcd nibble writer
package clnw_pkg;

    // request kinds
    localparam logic [2:0] KIND_INIT      = 3'd0;
    localparam logic [2:0] KIND_COMMAND   = 3'd1;
    localparam logic [2:0] KIND_DATA      = 3'd2;
    localparam logic [2:0] KIND_ROW_START = 3'd3;
    localparam logic [2:0] KIND_ROW_CHAR  = 3'd4;
    localparam logic [2:0] KIND_ROW_END   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_STARTUP = 2'd0;
    localparam logic [1:0] CFG_SETTLE  = 2'd1;
    localparam logic [1:0] CFG_COMMAND = 2'd2;

    // fixed lcd bytes and nibbles
    localparam logic [7:0] BYTE_ROW0  = 8'h80;
    localparam logic [7:0] BYTE_ROW1  = 8'hC0;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [3:0] NIB_WAKE   = 4'h3;
    localparam logic [3:0] NIB_4BIT   = 4'h2;

    // step numbers inside a request
    localparam logic [4:0] WAKE_STEPS     = 5'd4;
    localparam logic [4:0] INIT_LAST_STEP = 5'd11;
    localparam logic [4:0] PAD_LAST_STEP  = 5'd31;

    localparam logic [5:0] PAUSE_NONE = 6'd0;

    // one enable pulse worth of transfer
    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic [5:0] pause_before;
        logic [5:0] pause_after;
        logic       last;
    } xfer_t;

    // setup bytes sent after the wake-up nibbles
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h28;
            2'd1: b = 8'h08;
            2'd2: b = 8'h0C;
            2'd3: b = 8'h06;
            default: b = 8'h28;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/clnw_seq.sv
// request sequencer: steps through the transfers of one request, keeps the column count
module clnw_seq
    import clnw_pkg::*;
#(
    parameter int ROW_CHARS = 16,
    localparam int CW = $clog2(ROW_CHARS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [2:0]    kind,
    input  logic [7:0]    value,
    input  logic          row_select,
    input  logic [5:0]    startup_pause,
    input  logic [5:0]    settle_pause,
    input  logic [5:0]    command_pause,
    input  logic          out_ready,
    output logic          out_valid,
    output xfer_t         out_xfer,
    output logic          busy,
    output logic [CW-1:0] column
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;
    typedef enum logic [1:0] {MD_INIT, MD_BYTE, MD_PAD} mode_t;

    localparam logic [CW-1:0] COL_LIMIT = CW'(ROW_CHARS);

    state_t        state_reg, state_next;
    mode_t         mode_reg, mode_next;
    logic [4:0]    step_reg, step_next;
    logic [7:0]    byte_reg, byte_next;
    logic          rs_reg, rs_next;
    logic [CW-1:0] col_reg, col_next;

    logic          take;
    logic          emit;
    logic          row_open;
    logic [CW-1:0] col_inc;
    logic          col_full;
    logic [4:0]    step_off;
    logic [7:0]    cur_byte;
    xfer_t         x;

    // shared column unit: increment and compare against the row length
    assign col_inc  = col_reg + CW'(1);
    assign col_full = (col_inc == COL_LIMIT);
    assign row_open = (col_reg < COL_LIMIT);

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    assign out_valid = (state_reg == ST_RUN);
    assign emit      = out_valid && out_ready;
    assign busy      = (state_reg == ST_RUN);
    assign column    = col_reg;

    // byte for the current step
    assign step_off = step_reg - WAKE_STEPS;
    assign cur_byte = (mode_reg == MD_INIT) ? init_byte(step_off[2:1]) : byte_reg;

    // transfer for the current step
    always_comb
    begin
        x.reg_select   = rs_reg;
        x.nibble       = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
        x.pause_before = PAUSE_NONE;
        x.pause_after  = step_reg[0] ? command_pause : PAUSE_NONE;
        x.last         = 1'b0;
        unique case (mode_reg)
            MD_INIT:
            begin
                x.reg_select = 1'b0;
                if (step_reg < WAKE_STEPS)
                begin
                    x.nibble       = (step_reg == WAKE_STEPS - 5'd1) ? NIB_4BIT : NIB_WAKE;
                    x.pause_before = (step_reg < 5'd2) ? startup_pause : PAUSE_NONE;
                    x.pause_after  = (step_reg == 5'd0) ? PAUSE_NONE : settle_pause;
                end
                x.last = (step_reg == INIT_LAST_STEP);
            end
            MD_BYTE:
                x.last = step_reg[0];
            MD_PAD:
                x.last = step_reg[0] && (col_full || step_reg == PAD_LAST_STEP);
            default:
                x.last = 1'b1;
        endcase
    end

    assign out_xfer = x;

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        rs_next    = rs_reg;
        col_next   = col_reg;
        if (take)
        begin
            step_next = 5'd0;
            unique case (kind)
                KIND_INIT:
                begin
                    mode_next  = MD_INIT;
                    rs_next    = 1'b0;
                    state_next = ST_RUN;
                end
                KIND_COMMAND:
                begin
                    mode_next  = MD_BYTE;
                    byte_next  = value;
                    rs_next    = 1'b0;
                    state_next = ST_RUN;
                end
                KIND_DATA:
                begin
                    mode_next  = MD_BYTE;
                    byte_next  = value;
                    rs_next    = 1'b1;
                    state_next = ST_RUN;
                end
                KIND_ROW_START:
                begin
                    mode_next  = MD_BYTE;
                    byte_next  = row_select ? BYTE_ROW1 : BYTE_ROW0;
                    rs_next    = 1'b0;
                    col_next   = '0;
                    state_next = ST_RUN;
                end
                KIND_ROW_CHAR:
                begin
                    if (row_open)
                    begin
                        rs_next    = 1'b1;
                        state_next = ST_RUN;
                        if (value != 8'd0)
                        begin
                            mode_next = MD_BYTE;
                            byte_next = value;
                            col_next  = col_inc;
                        end
                        else
                        begin
                            // zero character closes the row
                            mode_next = MD_PAD;
                            byte_next = BYTE_SPACE;
                        end
                    end
                end
                KIND_ROW_END:
                begin
                    if (row_open)
                    begin
                        mode_next  = MD_PAD;
                        byte_next  = BYTE_SPACE;
                        rs_next    = 1'b1;
                        state_next = ST_RUN;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
        else if (emit)
        begin
            step_next = step_reg + 5'd1;
            if (mode_reg == MD_PAD && step_reg[0])
                col_next = col_inc;
            if (x.last)
                state_next = ST_IDLE;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MD_BYTE;
            step_reg  <= 5'd0;
            byte_reg  <= 8'd0;
            rs_reg    <= 1'b0;
            col_reg   <= COL_LIMIT;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
            rs_reg    <= rs_next;
            col_reg   <= col_next;
        end
    end

endmodule

// File: hw/rtl/clnw_out.sv
// output register between the sequencer and the master-side stream
module clnw_out
    import clnw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load_valid,
    output logic  load_ready,
    input  xfer_t load_xfer,
    output logic  m_tvalid,
    input  logic  m_tready,
    output xfer_t m_xfer
);

    logic  valid_reg, valid_next;
    xfer_t xfer_reg, xfer_next;

    assign load_ready = !valid_reg || m_tready;

    // hold the beat until taken, refill in the same cycle
    always_comb
    begin
        valid_next = valid_reg;
        xfer_next  = xfer_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
            if (load_valid)
                xfer_next = load_xfer;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        xfer_reg <= xfer_next;
    end

    assign m_tvalid = valid_reg;
    assign m_xfer   = xfer_reg;

endmodule

// File: hw/rtl/char_lcd_nibble_writer.sv
// top level of the character lcd nibble writer: register port, sequencer, output register
//
// Turns requests (init, command, data, row start, row char, row end) into the 4-bit
// enable-pulse transfers of a character LCD, one output beat per transfer, with tlast
// on the final transfer of each request. Once a request is accepted, the sequencer
// hands on one transfer per cycle while the master side keeps up. The transfer count
// of a request is 12 for init, 2 for command,
// data, row start and a written character, up to 32 for row padding (16 spaces at
// most per request), 0 for an ignored request. The next request is accepted in the
// cycle after the last transfer enters the output register. Pause registers sit on
// an APB port at byte addresses 0, 4 and 8 and should be written only while idle.
module char_lcd_nibble_writer
    import clnw_pkg::*;
#(
    parameter int ROW_CHARS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave-side request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] value, [8] row_select, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // master-side transfer stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] nibble, [9:4] pause_before, [15:10] pause_after
    output logic        m_tuser,   // [0] reg_select
    output logic        m_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(ROW_CHARS + 1);

    logic [5:0]    startup_reg, settle_reg, command_reg;
    logic          cfg_write;
    logic          seq_valid, seq_ready;
    xfer_t         seq_xfer, out_xfer;
    logic          seq_busy;
    logic [CW-1:0] column;

    // pause registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_reg <= 6'd12;
            settle_reg  <= 6'd1;
            command_reg <= 6'd2;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                CFG_STARTUP: startup_reg <= pwdata[5:0];
                CFG_SETTLE:  settle_reg  <= pwdata[5:0];
                CFG_COMMAND: command_reg <= pwdata[5:0];
                default:     startup_reg <= startup_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (paddr[3:2])
            CFG_STARTUP: prdata = {26'd0, startup_reg};
            CFG_SETTLE:  prdata = {26'd0, settle_reg};
            CFG_COMMAND: prdata = {26'd0, command_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // request sequencer
    clnw_seq #(
        .ROW_CHARS(ROW_CHARS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .kind         (s_tuser),
        .value        (s_tdata[7:0]),
        .row_select   (s_tdata[8]),
        .startup_pause(startup_reg),
        .settle_pause (settle_reg),
        .command_pause(command_reg),
        .out_ready    (seq_ready),
        .out_valid    (seq_valid),
        .out_xfer     (seq_xfer),
        .busy         (seq_busy),
        .column       (column)
    );

    // output register
    clnw_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_valid(seq_valid),
        .load_ready(seq_ready),
        .load_xfer (seq_xfer),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_xfer    (out_xfer)
    );

    assign m_tdata = {out_xfer.pause_after, out_xfer.pause_before, out_xfer.nibble};
    assign m_tuser = out_xfer.reg_select;
    assign m_tlast = out_xfer.last;

    // checks
    `include "char_lcd_nibble_writer_assert.svh"

    `CLNW_ASSERT_IMPLIES(a_column_in_range, 1'b1, column <= CW'(ROW_CHARS))
    `CLNW_ASSERT_NEXT(a_last_frees_seq, seq_valid && seq_ready && seq_xfer.last, !seq_busy)
    `CLNW_ASSERT_IMPLIES(a_stall_only_on_full, seq_busy && !seq_ready, m_tvalid && !m_tready)

endmodule

// File: bench/char_lcd_nibble_writer_tb.sv
// testbench for the character lcd nibble writer: request stream in, checked transfer stream out
`timescale 1ns / 100ps

module char_lcd_nibble_writer_tb;
    import clnw_pkg::*;

    localparam int ROW_CHARS = 16;
    localparam int PAD_MAX   = 16;

    // setup bytes that follow the wake-up nibbles
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_OFF   = 8'h08;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

    // unused request kinds
    localparam logic [2:0] KIND_SPARE_A = 3'd6;
    localparam logic [2:0] KIND_SPARE_B = 3'd7;

    localparam logic [5:0] PAUSE_MAX = 6'd63;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] value;
        logic       row_select;
    } lcd_req_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // stimulus and prediction state
    lcd_req_t   req_backlog[$];
    lcd_req_t   next_req;
    xfer_t      due_xfers[$];
    xfer_t      burst[$];
    logic       req_fire     = 1'b0;
    int         accepted_cnt = 0;
    int         err_cnt      = 0;
    int         useful_cnt   = 0;
    int         gen_col      = ROW_CHARS;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_left    = 0;

    // predictor copy of the block state
    logic [5:0] cfg_startup = 6'd12;
    logic [5:0] cfg_settle  = 6'd1;
    logic [5:0] cfg_command = 6'd2;
    int         model_col   = ROW_CHARS;

    char_lcd_nibble_writer #(.ROW_CHARS(ROW_CHARS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] value, [8] row_select, [15:9] zero
        .s_tuser  (s_tuser),    // [2:0] kind
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [3:0] nibble, [9:4] pause_before, [15:10] pause_after
        .m_tuser  (m_tuser),    // [0] reg_select
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task add_xfer(input logic rs, input logic [3:0] nib, input logic [5:0] pb,
                  input logic [5:0] pa);
        xfer_t x;
        x.reg_select   = rs;
        x.nibble       = nib;
        x.pause_before = pb;
        x.pause_after  = pa;
        x.last         = 1'b0;
        burst.push_back(x);
    endtask

    // full byte: high nibble, then low nibble with the command pause after it
    task add_byte(input logic rs, input logic [7:0] b);
        add_xfer(rs, b[7:4], PAUSE_NONE, PAUSE_NONE);
        add_xfer(rs, b[3:0], PAUSE_NONE, cfg_command);
    endtask

    // spaces up to the end of the row, at most PAD_MAX per request
    task pad_row;
        int k;
        k = 0;
        while (model_col < ROW_CHARS && k < PAD_MAX)
        begin
            add_byte(1'b1, BYTE_SPACE);
            model_col++;
            k++;
        end
    endtask

    // work out the transfers one request causes and queue them as due
    task expand_request(input lcd_req_t req);
        xfer_t tail;
        burst.delete();
        case (req.kind)
            KIND_INIT:
            begin
                add_xfer(1'b0, NIB_WAKE, cfg_startup, PAUSE_NONE);
                add_xfer(1'b0, NIB_WAKE, cfg_startup, cfg_settle);
                add_xfer(1'b0, NIB_WAKE, PAUSE_NONE, cfg_settle);
                add_xfer(1'b0, NIB_4BIT, PAUSE_NONE, cfg_settle);
                add_byte(1'b0, LCD_FUNC_SET);
                add_byte(1'b0, LCD_DISP_OFF);
                add_byte(1'b0, LCD_DISP_ON);
                add_byte(1'b0, LCD_ENTRY_MODE);
            end
            KIND_COMMAND:
                add_byte(1'b0, req.value);
            KIND_DATA:
                add_byte(1'b1, req.value);
            KIND_ROW_START:
            begin
                add_byte(1'b0, req.row_select ? BYTE_ROW1 : BYTE_ROW0);
                model_col = 0;
            end
            KIND_ROW_CHAR:
            begin
                if (model_col < ROW_CHARS)
                begin
                    if (req.value != 8'd0)
                    begin
                        add_byte(1'b1, req.value);
                        model_col++;
                    end
                    else
                        pad_row();
                end
            end
            KIND_ROW_END:
                pad_row();
            default:
                ;
        endcase
        if (burst.size() > 0)
        begin
            tail = burst[burst.size() - 1];
            tail.last = 1'b1;
            burst[burst.size() - 1] = tail;
            foreach (burst[i])
                due_xfers.push_back(burst[i]);
        end
    endtask

    // queue a request, tracking roughly which ones will do any work
    task queue_req(input logic [2:0] k, input logic [7:0] v, input logic r);
        lcd_req_t req;
        req.kind       = k;
        req.value      = v;
        req.row_select = r;
        req_backlog.push_back(req);
        case (k)
            KIND_INIT, KIND_COMMAND, KIND_DATA:
                useful_cnt++;
            KIND_ROW_START:
            begin
                useful_cnt++;
                gen_col = 0;
            end
            KIND_ROW_CHAR:
            begin
                if (gen_col < ROW_CHARS)
                begin
                    useful_cnt++;
                    gen_col = (v != 8'd0) ? gen_col + 1 : ROW_CHARS;
                end
            end
            KIND_ROW_END:
            begin
                if (gen_col < ROW_CHARS)
                    useful_cnt++;
                gen_col = ROW_CHARS;
            end
            default:
                ;
        endcase
    endtask

    // mostly whole rows with random content, some bytes, inits and noise
    task gen_traffic(input int target);
        int goal;
        int pick;
        int nchar;
        goal = useful_cnt + target;
        while (useful_cnt < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                queue_req(KIND_ROW_START, 8'($urandom), 1'($urandom_range(1)));
                nchar = ($urandom_range(3) == 0) ? $urandom_range(20, 14) : $urandom_range(8);
                for (int i = 0; i < nchar; i++)
                    queue_req(KIND_ROW_CHAR, 8'($urandom_range(255, 1)),
                              1'($urandom_range(1)));
                case ($urandom_range(3))
                    0: queue_req(KIND_ROW_END, 8'($urandom), 1'($urandom_range(1)));
                    1: queue_req(KIND_ROW_CHAR, 8'h00, 1'($urandom_range(1)));
                    2: ;
                    default:
                    begin
                        queue_req(KIND_ROW_END, 8'($urandom), 1'($urandom_range(1)));
                        queue_req(KIND_ROW_END, 8'($urandom), 1'($urandom_range(1)));
                    end
                endcase
            end
            else if (pick < 68)
                queue_req(KIND_COMMAND, 8'($urandom), 1'($urandom_range(1)));
            else if (pick < 82)
                queue_req(KIND_DATA, 8'($urandom), 1'($urandom_range(1)));
            else if (pick < 87)
                queue_req(KIND_INIT, 8'($urandom), 1'($urandom_range(1)));
            else if (pick < 94)
                queue_req($urandom_range(1) ? KIND_ROW_END : KIND_ROW_CHAR,
                          $urandom_range(3) == 0 ? 8'h00 : 8'($urandom),
                          1'($urandom_range(1)));
            else
                queue_req($urandom_range(1) ? KIND_SPARE_B : KIND_SPARE_A,
                          8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    // register write: setup cycle, then access cycle
    task apb_write(input logic [1:0] idx, input logic [5:0] v);
        logic [31:0] bits;
        bits = $urandom;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {bits[31:6], v};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_STARTUP: cfg_startup = v;
            CFG_SETTLE:  cfg_settle  = v;
            CFG_COMMAND: cfg_command = v;
            default:     ;
        endcase
    endtask

    // wait until every request is in and every transfer is out, then let the block settle
    task wait_idle;
        while (!(req_backlog.size() == 0 && !s_tvalid && due_xfers.size() == 0))
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || req_fire)
        begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = req_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, next_req.row_select, next_req.value};
                s_tuser  <= next_req.kind;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // transfer receiver with random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // predict on each accepted request, check each accepted transfer
    always @(posedge clk)
    begin
        xfer_t got;
        xfer_t want;
        req_fire = rst_n && s_tvalid && s_tready;
        if (req_fire)
        begin
            expand_request('{s_tuser, s_tdata[7:0], s_tdata[8]});
            accepted_cnt++;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.reg_select   = m_tuser;
            got.nibble       = m_tdata[3:0];
            got.pause_before = m_tdata[9:4];
            got.pause_after  = m_tdata[15:10];
            got.last         = m_tlast;
            if (due_xfers.size() == 0)
            begin
                err_cnt++;
                $display({"%0t: unexpected transfer expected none, ",
                          "actual rs=%0b nib=%h pb=%0d pa=%0d last=%0b"},
                         $time, got.reg_select, got.nibble, got.pause_before,
                         got.pause_after, got.last);
            end
            else
            begin
                want = due_xfers.pop_front();
                if (got !== want)
                begin
                    err_cnt++;
                    $display({"%0t: transfer mismatch expected rs=%0b nib=%h pb=%0d pa=%0d ",
                              "last=%0b, actual rs=%0b nib=%h pb=%0d pa=%0d last=%0b"},
                             $time, want.reg_select, want.nibble, want.pause_before,
                             want.pause_after, want.last, got.reg_select, got.nibble,
                             got.pause_before, got.pause_after, got.last);
                end
            end
        end
    end

    // hang guard
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // test sequence
    initial
    begin
        int mark;
        send_idle_pct = 19;
        recv_idle_pct = 55;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset pauses, byte extremes, ignored kinds, row edge cases
        queue_req(KIND_INIT, 8'h00, 1'b0);
        queue_req(KIND_COMMAND, 8'h00, 1'b0);
        queue_req(KIND_COMMAND, 8'hFF, 1'b1);
        queue_req(KIND_DATA, 8'h00, 1'b0);
        queue_req(KIND_DATA, 8'hFF, 1'b0);
        queue_req(KIND_DATA, 8'hA5, 1'b1);
        queue_req(KIND_SPARE_A, 8'h5A, 1'b0);
        queue_req(KIND_SPARE_B, 8'hFF, 1'b1);
        queue_req(KIND_ROW_CHAR, 8'h41, 1'b0);
        queue_req(KIND_ROW_END, 8'h00, 1'b0);
        queue_req(KIND_ROW_START, 8'h00, 1'b0);
        queue_req(KIND_ROW_CHAR, 8'h41, 1'b1);
        queue_req(KIND_ROW_CHAR, 8'hFF, 1'b0);
        queue_req(KIND_ROW_CHAR, 8'h00, 1'b0);
        queue_req(KIND_ROW_CHAR, 8'h42, 1'b0);
        queue_req(KIND_ROW_START, 8'hFF, 1'b1);
        queue_req(KIND_ROW_END, 8'hFF, 1'b1);
        queue_req(KIND_ROW_END, 8'h00, 1'b0);
        queue_req(KIND_ROW_START, 8'h00, 1'b0);
        queue_req(KIND_ROW_CHAR, 8'h7E, 1'b0);
        queue_req(KIND_ROW_CHAR, 8'h01, 1'b1);
        queue_req(KIND_ROW_END, 8'h00, 1'b0);
        wait_idle();

        // all pauses at maximum
        apb_write(CFG_STARTUP, PAUSE_MAX);
        apb_write(CFG_SETTLE, PAUSE_MAX);
        apb_write(CFG_COMMAND, PAUSE_MAX);
        queue_req(KIND_INIT, 8'($urandom), 1'($urandom_range(1)));
        gen_traffic(80);
        wait_idle();

        // all pauses zero, idling swapped
        send_idle_pct = 55;
        recv_idle_pct = 19;
        apb_write(CFG_STARTUP, PAUSE_NONE);
        apb_write(CFG_SETTLE, PAUSE_NONE);
        apb_write(CFG_COMMAND, PAUSE_NONE);
        queue_req(KIND_INIT, 8'($urandom), 1'($urandom_range(1)));
        gen_traffic(80);
        wait_idle();

        // random pauses, no idling, one long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apb_write(CFG_STARTUP, 6'($urandom));
        apb_write(CFG_SETTLE, 6'($urandom));
        apb_write(CFG_COMMAND, 6'($urandom));
        mark = accepted_cnt;
        queue_req(KIND_INIT, 8'($urandom), 1'($urandom_range(1)));
        gen_traffic(80);
        while (accepted_cnt < mark + 30)
            @(posedge clk);
        hold_left = 300;
        wait_idle();

        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/clnw_pkg.sv
hw/rtl/clnw_seq.sv
hw/rtl/clnw_out.sv
hw/rtl/char_lcd_nibble_writer.sv
bench/char_lcd_nibble_writer_tb.sv
